>>> hdl/mpd_pkg.sv
package mpd_pkg;

    // Frame limits
    localparam int MAX_PATH_BYTES    = 64;
    localparam int MAX_PAYLOAD_BYTES = 256;

    localparam logic [9:0] PAYLOAD_CNT_MAX = 10'd1023;
    localparam logic [1:0] HASH_CODE_UNSUPPORTED = 2'd3;
    localparam logic [1:0] TRANSPORT_LAST_SUB = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLOOD_CODE  = 2'd0;
    localparam logic [1:0] CFG_DIRECT_CODE = 2'd1;

    localparam int TDATA_W = 72;

    typedef enum logic [2:0] {
        PH_HEADER    = 3'd0,
        PH_TRANSPORT = 3'd1,
        PH_PLEN      = 3'd2,
        PH_PATH      = 3'd3,
        PH_PAYLOAD   = 3'd4,
        PH_DISCARD   = 3'd5
    } mpd_phase_t;

    typedef enum logic [2:0] {
        CLS_HEADER    = 3'd0,
        CLS_TRANSPORT = 3'd1,
        CLS_PLEN      = 3'd2,
        CLS_PATH      = 3'd3,
        CLS_PAYLOAD   = 3'd4,
        CLS_DISCARD   = 3'd5
    } mpd_class_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_TOO_SHORT   = 2'd1,
        ST_FORMAT      = 2'd2,
        ST_UNSUPPORTED = 2'd3
    } mpd_status_t;

    typedef struct packed {
        logic [1:0] flood_code;
        logic [1:0] direct_code;
    } mpd_route_cfg_t;

    typedef struct packed {
        logic [7:0]  byte_out;
        mpd_class_t  byte_class;
        logic        frame_done;
        mpd_status_t status;
        logic [1:0]  route_kind;
        logic [3:0]  payload_kind;
        logic [1:0]  format_version;
        logic [15:0] transport_code_a;
        logic [15:0] transport_code_b;
        logic [5:0]  hops;
        logic [2:0]  hash_bytes;
        logic [9:0]  payload_count;
    } mpd_result_t;

endpackage

>>> hdl/mesh_packet_deframer.sv
// Mesh frame deframer. Takes a received frame one byte per beat on the slave
// stream (s_tlast marks the final byte) and returns exactly one beat per byte
// on the master stream: the byte itself, its class in m_tuser (header,
// transport code, path length, path hash, payload, or discarded after a fatal
// error), and on the last byte of a frame (m_tlast high) the parsed header,
// transport codes, hop count, hash size, saturating payload count and a
// status (ok, too short, format error, unsupported hash size). Path and
// payload bytes are streamed through, never buffered. Throughput is one byte
// per clock: the next parse state is computed combinationally, and a
// two-entry output buffer keeps s_tready registered so a stalled result does
// not stall input until both entries are full; each result is registered there.
// The two transport route codes are written through the cfg port (index 0
// flood, index 1 direct) by the user only while idle; the block does not enforce it.
module mesh_packet_deframer
    import mpd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // input bytes
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] data_byte
    input  logic               s_tlast,   // last_byte
    // tagged results
    output logic               m_tvalid,
    input  logic               m_tready,
    // [7:0] byte_out, [9:8] status, [11:10] route_kind, [15:12] payload_kind,
    // [17:16] format_version, [33:18] transport_code_a, [49:34]
    // transport_code_b, [55:50] hops, [58:56] hash_bytes, [68:59]
    // payload_count, [71:69] zero
    output logic [TDATA_W-1:0] m_tdata,
    output logic [2:0]         m_tuser,   // [2:0] byte_class
    output logic               m_tlast,   // frame_done
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [1:0]         cfg_data
);

    mpd_route_cfg_t route_cfg_reg;
    mpd_result_t    parse_result;
    mpd_result_t    out_result;
    logic           s_fire;

    // Config writes always land; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            route_cfg_reg.flood_code  <= 2'd0;
            route_cfg_reg.direct_code <= 2'd3;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FLOOD_CODE)
            begin
                route_cfg_reg.flood_code <= cfg_data;
            end
            else if (cfg_index == CFG_DIRECT_CODE)
            begin
                route_cfg_reg.direct_code <= cfg_data;
            end
        end
    end

    // Advance the parser only on an accepted input beat.
    assign s_fire = s_tvalid && s_tready;

    mpd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s_fire),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .route_cfg (route_cfg_reg),
        .result    (parse_result)
    );

    // Hold results here while the sink stalls.
    mpd_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (parse_result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {3'b000,
                      out_result.payload_count,
                      out_result.hash_bytes,
                      out_result.hops,
                      out_result.transport_code_b,
                      out_result.transport_code_a,
                      out_result.format_version,
                      out_result.payload_kind,
                      out_result.route_kind,
                      out_result.status,
                      out_result.byte_out};
    assign m_tuser = out_result.byte_class;
    assign m_tlast = out_result.frame_done;

endmodule

>>> hdl/mpd_parser.sv
module mpd_parser
    import mpd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  logic [7:0]     data_byte,
    input  logic           last_byte,
    input  mpd_route_cfg_t route_cfg,
    output mpd_result_t    result
);

    mpd_phase_t  phase_reg, phase_next;
    logic [1:0]  sub_reg, sub_next;
    logic [7:0]  header_reg, header_next;
    logic [15:0] code_a_reg, code_a_next;
    logic [15:0] code_b_reg, code_b_next;
    logic [5:0]  hop_reg, hop_next;
    logic [2:0]  hash_size_reg, hash_size_next;
    logic [7:0]  path_left_reg, path_left_next;
    logic [9:0]  payload_cnt_reg, payload_cnt_next;
    mpd_status_t error_reg, error_next;
    mpd_class_t  cls;

    logic [2:0]  plen_size;
    logic [8:0]  path_bytes;
    logic        path_too_long;
    logic        route_match;
    logic        got_plen;
    mpd_status_t status;

    assign plen_size     = {1'b0, data_byte[7:6]} + 3'd1;
    assign path_bytes    = 9'(data_byte[5:0]) * 9'(plen_size);
    assign path_too_long = path_bytes > 9'(MAX_PATH_BYTES);
    assign route_match   = (data_byte[1:0] == route_cfg.flood_code)
                        || (data_byte[1:0] == route_cfg.direct_code);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                phase_next = route_match ? PH_TRANSPORT : PH_PLEN;
            end
            PH_TRANSPORT:
            begin
                if (sub_reg == TRANSPORT_LAST_SUB)
                begin
                    phase_next = PH_PLEN;
                end
            end
            PH_PLEN:
            begin
                if (data_byte[7:6] == HASH_CODE_UNSUPPORTED || path_too_long)
                begin
                    phase_next = PH_DISCARD;
                end
                else
                begin
                    phase_next = (path_bytes[7:0] != 8'd0) ? PH_PATH : PH_PAYLOAD;
                end
            end
            PH_PATH:
            begin
                if (path_left_next == 8'd0)
                begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:  phase_next = PH_PAYLOAD;
            PH_DISCARD:  phase_next = PH_DISCARD;
            default:     phase_next = PH_DISCARD;
        endcase
    end

    // Field capture and class tag
    always_comb
    begin
        header_next      = header_reg;
        sub_next         = sub_reg;
        code_a_next      = code_a_reg;
        code_b_next      = code_b_reg;
        hop_next         = hop_reg;
        hash_size_next   = hash_size_reg;
        path_left_next   = path_left_reg;
        payload_cnt_next = payload_cnt_reg;
        error_next       = error_reg;
        cls              = CLS_DISCARD;
        unique case (phase_reg)
            PH_HEADER:
            begin
                cls         = CLS_HEADER;
                header_next = data_byte;
                sub_next    = 2'd0;
            end
            PH_TRANSPORT:
            begin
                cls      = CLS_TRANSPORT;
                sub_next = sub_reg + 2'd1;
                unique case (sub_reg)
                    2'd0:    code_a_next[7:0]  = data_byte;
                    2'd1:    code_a_next[15:8] = data_byte;
                    2'd2:    code_b_next[7:0]  = data_byte;
                    default: code_b_next[15:8] = data_byte;
                endcase
            end
            PH_PLEN:
            begin
                cls            = CLS_PLEN;
                hop_next       = data_byte[5:0];
                hash_size_next = plen_size;
                if (data_byte[7:6] == HASH_CODE_UNSUPPORTED)
                begin
                    error_next = ST_UNSUPPORTED;
                end
                else if (path_too_long)
                begin
                    error_next = ST_FORMAT;
                end
                else
                begin
                    path_left_next = path_bytes[7:0];
                end
            end
            PH_PATH:
            begin
                cls = CLS_PATH;
                if (path_left_reg != 8'd0)
                begin
                    path_left_next = path_left_reg - 8'd1;
                end
            end
            PH_PAYLOAD:
            begin
                cls = CLS_PAYLOAD;
                if (payload_cnt_reg != PAYLOAD_CNT_MAX)
                begin
                    payload_cnt_next = payload_cnt_reg + 10'd1;
                end
            end
            PH_DISCARD:  cls = CLS_DISCARD;
            default:     cls = CLS_DISCARD;
        endcase
    end

    // End-of-frame report
    always_comb
    begin
        got_plen = (phase_next == PH_PATH) || (phase_next == PH_PAYLOAD)
                || (phase_next == PH_DISCARD);
        priority if (error_next != ST_OK)
        begin
            status = error_next;
        end
        else if (!got_plen)
        begin
            status = ST_TOO_SHORT;
        end
        else if (phase_next == PH_PATH)
        begin
            status = ST_FORMAT;
        end
        else if (payload_cnt_next > 10'(MAX_PAYLOAD_BYTES))
        begin
            status = ST_FORMAT;
        end
        else
        begin
            status = ST_OK;
        end

        result            = '0;
        result.byte_out   = data_byte;
        result.byte_class = cls;
        result.status     = ST_OK;
        if (last_byte)
        begin
            result.frame_done     = 1'b1;
            result.status         = status;
            result.route_kind     = header_next[1:0];
            result.payload_kind   = header_next[5:2];
            result.format_version = header_next[7:6];
            result.payload_count  = payload_cnt_next;
            if (got_plen)
            begin
                result.transport_code_a = code_a_next;
                result.transport_code_b = code_b_next;
                result.hops             = hop_next;
                result.hash_bytes       = hash_size_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            sub_reg         <= '0;
            header_reg      <= '0;
            code_a_reg      <= '0;
            code_b_reg      <= '0;
            hop_reg         <= '0;
            hash_size_reg   <= '0;
            path_left_reg   <= '0;
            payload_cnt_reg <= '0;
            error_reg       <= ST_OK;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                // clear for the next frame
                phase_reg       <= PH_HEADER;
                sub_reg         <= '0;
                header_reg      <= '0;
                code_a_reg      <= '0;
                code_b_reg      <= '0;
                hop_reg         <= '0;
                hash_size_reg   <= '0;
                path_left_reg   <= '0;
                payload_cnt_reg <= '0;
                error_reg       <= ST_OK;
            end
            else
            begin
                phase_reg       <= phase_next;
                sub_reg         <= sub_next;
                header_reg      <= header_next;
                code_a_reg      <= code_a_next;
                code_b_reg      <= code_b_next;
                hop_reg         <= hop_next;
                hash_size_reg   <= hash_size_next;
                path_left_reg   <= path_left_next;
                payload_cnt_reg <= payload_cnt_next;
                error_reg       <= error_next;
            end
        end
    end

    a_last_returns_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_byte |=> phase_reg == PH_HEADER)
        else $error("parser did not return to header after last byte");

    a_path_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PATH |-> path_left_reg != 8'd0)
        else $error("path phase with no path bytes left");

    a_discard_iff_error: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DISCARD) == (error_reg != ST_OK))
        else $error("discard phase and error code disagree");

endmodule

>>> hdl/mpd_out_skid.sv
module mpd_out_skid
    import mpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mpd_result_t in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mpd_result_t out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    mpd_result_t out_data_reg;
    mpd_result_t skid_data_reg;
    logic        accept;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            // output slot frees: drain skid first, else take the new beat
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (accept)
        begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output slot is empty");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid beat not moved to output");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with an empty output slot");

endmodule
